@@ design/igmp_gmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and helpers for the IGMP group membership table.
// No dependencies.
package igmp_gmt_pkg;

    localparam int TABLE_DEPTH = 32;

    localparam logic [1:0] ACT_REPORT = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [2:0] EV_START   = 3'd0;
    localparam logic [2:0] EV_STOP    = 3'd1;
    localparam logic [2:0] EV_GENERAL = 3'd2;
    localparam logic [2:0] EV_GROUP   = 3'd3;
    localparam logic [2:0] EV_FULL    = 3'd4;

    localparam logic [7:0] RT_V1_REPORT = 8'h12;
    localparam logic [7:0] RT_V2_REPORT = 8'h16;
    localparam logic [7:0] RT_V2_LEAVE  = 8'h17;
    localparam logic [7:0] RT_IS_EXCL   = 8'd2;
    localparam logic [7:0] RT_TO_INCL   = 8'd3;
    localparam logic [7:0] RT_TO_EXCL   = 8'd4;

    localparam logic [2:0] CFG_LOCAL_ADDR  = 3'd0;
    localparam logic [2:0] CFG_RANGE_BASE  = 3'd1;
    localparam logic [2:0] CFG_RANGE_MASK  = 3'd2;
    localparam logic [2:0] CFG_QUERY_IVL   = 3'd3;
    localparam logic [2:0] CFG_RESP_IVL    = 3'd4;
    localparam logic [2:0] CFG_LAST_MEMBER = 3'd5;
    localparam logic [2:0] CFG_ROBUSTNESS  = 3'd6;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  record_type;
        logic [31:0] group_addr;
        logic [31:0] sender_addr;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] event_group;
        logic [7:0]  max_resp_code;
        logic        is_querier;
        logic        last;
    } out_item_t;

    // per-entry tick decision
    typedef struct packed {
        logic stop;
        logic rtx_fire;
        logic v1_clear;
    } walk_dec_t;

    // timer t has run out when now - t lies in 1 .. 2^31-1
    function automatic logic run_out(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return (d != 32'd0) && !d[31];
    endfunction

endpackage
`default_nettype wire

@@ design/igmp_gmt_walk_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Tick-time decision for one table entry: expiry, retransmit, v1-host timer.
// Depends on igmp_gmt_pkg.
module igmp_gmt_walk_eval (
    input  wire logic                   valid,
    input  wire logic                   querier,
    input  wire logic [31:0]            now,
    input  wire logic [31:0]            expiry,
    input  wire logic                   rtx_valid,
    input  wire logic [31:0]            rtx_time,
    input  wire logic                   v1_valid,
    input  wire logic [31:0]            v1_time,
    output igmp_gmt_pkg::walk_dec_t     dec
);
    logic exp_out, rtx_out, v1_out;

    assign exp_out = igmp_gmt_pkg::run_out(now, expiry);
    assign rtx_out = igmp_gmt_pkg::run_out(now, rtx_time);
    assign v1_out  = igmp_gmt_pkg::run_out(now, v1_time);

    always_comb begin
        dec.stop     = valid && exp_out;
        dec.rtx_fire = valid && !exp_out && querier && rtx_valid && rtx_out;
        dec.v1_clear = valid && !exp_out && !(querier && rtx_valid && rtx_out)
                       && v1_valid && v1_out;
    end
endmodule
`default_nettype wire

@@ design/igmp_group_membership_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// IGMP querier group membership table, one item at a time.
// Tick: walks the table one entry per cycle while results do not stall.
// Report/leave: slot search one entry per cycle, ending early on a match.
// Query or action three: straight to finish; out-of-range or unknown record: ends at the first scan step.
// Results leave through a pending slot and a one-beat output register.
// Reset (aresetn low, synchronous): control and config registers to defaults, table emptied.
module igmp_group_membership_table #(
    parameter int TABLE_DEPTH = igmp_gmt_pkg::TABLE_DEPTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output      logic                    s_ready,
    input  wire igmp_gmt_pkg::in_item_t  s_data,
    output      logic                    m_valid,
    input  wire logic                    m_ready,
    output      igmp_gmt_pkg::out_item_t m_data,
    input  wire logic                    cfg_valid,
    output      logic                    cfg_ready,
    input  wire logic [2:0]              cfg_index,
    input  wire logic [31:0]             cfg_data
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_APPLY  = 6'b000100,
        ST_GQ     = 6'b001000,
        ST_WALK   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg;

    logic [31:0] local_reg, base_reg, mask_reg;
    logic [15:0] qi_reg;
    logic [7:0]  ri_reg;
    logic [4:0]  lmi_reg;
    logic [1:0]  rob_reg;

    logic [31:0] now_reg, gq_due_reg;
    logic [1:0]  startup_reg;
    logic        querier_reg;

    logic [TABLE_DEPTH-1:0] ent_v_reg, rtx_v_reg, v1_v_reg;
    logic [31:0] grp_reg  [TABLE_DEPTH];
    logic [31:0] rep_reg  [TABLE_DEPTH];
    logic [31:0] exp_reg  [TABLE_DEPTH];
    logic [31:0] rtxt_reg [TABLE_DEPTH];
    logic [31:0] v1t_reg  [TABLE_DEPTH];

    igmp_gmt_pkg::in_item_t item_reg;
    logic [IW-1:0] idx_reg, slot_reg, free_reg;
    logic          found_reg, free_ok_reg;

    logic                    out_v_reg, pend_v_reg;
    igmp_gmt_pkg::out_item_t out_reg, pend_reg;
    igmp_gmt_pkg::out_item_t out_next, pend_next;

    // emit path
    logic        want_emit, can_emit, out_free, go, out_load, pend_clear;
    logic [2:0]  ev_kind;
    logic [31:0] ev_group;
    logic [7:0]  ev_code;

    logic [31:0] gmi_w;
    logic        in_range, is_report, is_leave, leave_ok;
    logic [6:0]  leave_mult;
    igmp_gmt_pkg::walk_dec_t dec;

    assign gmi_w      = 32'({qi_reg, 1'b0}) + 32'(ri_reg);
    assign in_range   = (item_reg.group_addr & mask_reg) == base_reg;
    assign is_report  = item_reg.record_type == igmp_gmt_pkg::RT_V1_REPORT
                     || item_reg.record_type == igmp_gmt_pkg::RT_V2_REPORT
                     || item_reg.record_type == igmp_gmt_pkg::RT_IS_EXCL
                     || item_reg.record_type == igmp_gmt_pkg::RT_TO_EXCL;
    assign is_leave   = item_reg.record_type == igmp_gmt_pkg::RT_V2_LEAVE
                     || item_reg.record_type == igmp_gmt_pkg::RT_TO_INCL;
    assign leave_ok   = found_reg && !v1_v_reg[slot_reg]
                     && rep_reg[slot_reg] == item_reg.sender_addr;
    assign leave_mult = 7'(querier_reg ? lmi_reg : 5'd1) * 7'(rob_reg);

    igmp_gmt_walk_eval u_eval (
        .valid     (ent_v_reg[idx_reg]),
        .querier   (querier_reg),
        .now       (now_reg),
        .expiry    (exp_reg[idx_reg]),
        .rtx_valid (rtx_v_reg[idx_reg]),
        .rtx_time  (rtxt_reg[idx_reg]),
        .v1_valid  (v1_v_reg[idx_reg]),
        .v1_time   (v1t_reg[idx_reg]),
        .dec       (dec)
    );

    always_comb begin
        want_emit = 1'b0;
        ev_kind   = igmp_gmt_pkg::EV_START;
        ev_group  = item_reg.group_addr;
        ev_code   = 8'd0;
        case (state_reg)
            ST_GQ: begin
                if (igmp_gmt_pkg::run_out(now_reg, gq_due_reg)) begin
                    want_emit = 1'b1;
                    ev_kind   = igmp_gmt_pkg::EV_GENERAL;
                    ev_group  = 32'd0;
                    ev_code   = ri_reg;
                end
            end
            ST_WALK: begin
                ev_group = grp_reg[idx_reg];
                if (dec.stop) begin
                    want_emit = 1'b1;
                    ev_kind   = igmp_gmt_pkg::EV_STOP;
                end else if (dec.rtx_fire) begin
                    want_emit = 1'b1;
                    ev_kind   = igmp_gmt_pkg::EV_GROUP;
                    ev_code   = 8'(lmi_reg);
                end
            end
            ST_APPLY: begin
                if (is_report && !found_reg) begin
                    want_emit = 1'b1;
                    ev_kind   = free_ok_reg ? igmp_gmt_pkg::EV_START : igmp_gmt_pkg::EV_FULL;
                end else if (!is_report && leave_ok && querier_reg) begin
                    want_emit = 1'b1;
                    ev_kind   = igmp_gmt_pkg::EV_GROUP;
                    ev_code   = 8'(lmi_reg);
                end
            end
            default: ;
        endcase
    end

    assign out_free = !out_v_reg || m_ready;
    assign can_emit = !pend_v_reg || out_free;
    assign go       = !want_emit || can_emit;

    // the pending beat moves out when a newer one arrives or the item ends
    assign out_load   = pend_v_reg && ((want_emit && can_emit)
                                       || (state_reg == ST_FINISH && out_free));
    assign pend_clear = state_reg == ST_FINISH && pend_v_reg && out_free;

    always_comb begin
        out_next            = pend_reg;
        out_next.is_querier = querier_reg;
        out_next.last       = state_reg == ST_FINISH;
        pend_next               = '0;
        pend_next.event_kind    = ev_kind;
        pend_next.event_group   = ev_group;
        pend_next.max_resp_code = ev_code;
    end

    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_v_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            local_reg   <= 32'd0;
            base_reg    <= 32'hE000_0000;
            mask_reg    <= 32'hF000_0000;
            qi_reg      <= 16'd1250;
            ri_reg      <= 8'd100;
            lmi_reg     <= 5'd1;
            rob_reg     <= 2'd2;
            now_reg     <= 32'd0;
            gq_due_reg  <= 32'd0;
            startup_reg <= 2'd2;
            querier_reg <= 1'b1;
            ent_v_reg   <= '0;
            rtx_v_reg   <= '0;
            v1_v_reg    <= '0;
            out_v_reg   <= 1'b0;
            pend_v_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    igmp_gmt_pkg::CFG_LOCAL_ADDR:  local_reg <= cfg_data;
                    igmp_gmt_pkg::CFG_RANGE_BASE:  base_reg  <= cfg_data;
                    igmp_gmt_pkg::CFG_RANGE_MASK:  mask_reg  <= cfg_data;
                    igmp_gmt_pkg::CFG_QUERY_IVL:   qi_reg    <= cfg_data[15:0];
                    igmp_gmt_pkg::CFG_RESP_IVL:    ri_reg    <= cfg_data[7:0];
                    igmp_gmt_pkg::CFG_LAST_MEMBER: lmi_reg   <= cfg_data[4:0];
                    igmp_gmt_pkg::CFG_ROBUSTNESS:  rob_reg   <= cfg_data[1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                out_reg   <= out_next;
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end

            // new event goes to the pending slot; the older one moves out
            if (want_emit && can_emit) begin
                pend_v_reg <= 1'b1;
                pend_reg   <= pend_next;
            end else if (pend_clear) begin
                pend_v_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg    <= s_data;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        free_ok_reg <= 1'b0;
                        case (s_data.action)
                            igmp_gmt_pkg::ACT_REPORT: state_reg <= ST_SCAN;
                            igmp_gmt_pkg::ACT_QUERY: begin
                                if (s_data.sender_addr < local_reg) begin
                                    querier_reg <= 1'b0;
                                    startup_reg <= 2'd0;
                                    gq_due_reg  <= now_reg + 32'({qi_reg, 1'b0})
                                                   + 32'(ri_reg[7:1]);
                                end
                                state_reg <= ST_FINISH;
                            end
                            igmp_gmt_pkg::ACT_TICK: begin
                                now_reg   <= now_reg + 32'd1;
                                state_reg <= ST_GQ;
                            end
                            default: state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (!in_range || !(is_report || is_leave)) begin
                        state_reg <= ST_FINISH;
                    end else if (ent_v_reg[idx_reg]
                                 && grp_reg[idx_reg] == item_reg.group_addr) begin
                        found_reg <= 1'b1;
                        slot_reg  <= idx_reg;
                        state_reg <= ST_APPLY;
                    end else begin
                        if (!ent_v_reg[idx_reg] && !free_ok_reg) begin
                            free_ok_reg <= 1'b1;
                            free_reg    <= idx_reg;
                        end
                        if (idx_reg == LAST_IDX) state_reg <= ST_APPLY;
                        else idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_APPLY: begin
                    if (go) begin
                        state_reg <= ST_FINISH;
                        if (is_report) begin
                            if (found_reg || free_ok_reg) begin
                                if (found_reg) begin
                                    exp_reg[slot_reg]   <= now_reg + gmi_w;
                                    rep_reg[slot_reg]   <= item_reg.sender_addr;
                                    rtx_v_reg[slot_reg] <= 1'b0;
                                    if (item_reg.record_type == igmp_gmt_pkg::RT_V1_REPORT) begin
                                        v1_v_reg[slot_reg] <= 1'b1;
                                        v1t_reg[slot_reg]  <= now_reg + gmi_w;
                                    end
                                end else begin
                                    ent_v_reg[free_reg] <= 1'b1;
                                    grp_reg[free_reg]   <= item_reg.group_addr;
                                    exp_reg[free_reg]   <= now_reg + gmi_w;
                                    rep_reg[free_reg]   <= item_reg.sender_addr;
                                    rtx_v_reg[free_reg] <= 1'b0;
                                    v1_v_reg[free_reg]  <= item_reg.record_type
                                                           == igmp_gmt_pkg::RT_V1_REPORT;
                                    v1t_reg[free_reg]   <= now_reg + gmi_w;
                                end
                            end
                        end else if (leave_ok) begin
                            exp_reg[slot_reg]   <= now_reg + 32'(leave_mult);
                            rep_reg[slot_reg]   <= 32'd0;
                            rtx_v_reg[slot_reg] <= 1'b1;
                            rtxt_reg[slot_reg]  <= now_reg + 32'(lmi_reg);
                        end
                    end
                end
                ST_GQ: begin
                    if (go) begin
                        if (want_emit) begin
                            querier_reg <= 1'b1;
                            if (startup_reg != 2'd0) begin
                                gq_due_reg  <= now_reg + 32'(qi_reg[15:2]);
                                startup_reg <= startup_reg - 2'd1;
                            end else begin
                                gq_due_reg <= now_reg + 32'(qi_reg);
                            end
                        end
                        idx_reg   <= '0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (go) begin
                        if (dec.stop) begin
                            ent_v_reg[idx_reg] <= 1'b0;
                            rtx_v_reg[idx_reg] <= 1'b0;
                            v1_v_reg[idx_reg]  <= 1'b0;
                        end else if (dec.rtx_fire) begin
                            rtxt_reg[idx_reg] <= now_reg + 32'(lmi_reg);
                        end else if (dec.v1_clear) begin
                            v1_v_reg[idx_reg] <= 1'b0;
                        end
                        if (idx_reg == LAST_IDX) state_reg <= ST_FINISH;
                        else idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (!pend_v_reg || out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/igmp_gmt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the group membership table, bound to the top level.
// Depends on igmp_gmt_pkg.
module igmp_gmt_checker (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire igmp_gmt_pkg::out_item_t m_data
);
    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.event_kind <= igmp_gmt_pkg::EV_FULL)
        else $error("bad event kind");

    // a general query carries no group and always sets the querier flag
    a_general: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == igmp_gmt_pkg::EV_GENERAL |->
            m_data.event_group == 32'd0 && m_data.is_querier)
        else $error("general query malformed");
endmodule

bind igmp_group_membership_table igmp_gmt_checker u_igmp_gmt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
